FILE: design/gcps_pkg.sv
// ----------------------------------------------------------------------------
// gcps_pkg
// Shared types and constants for the controller port shifter.
// ----------------------------------------------------------------------------
package gcps_pkg;

   localparam int PAD_W   = 8;
   localparam int PORT_W  = 20;
   localparam int DATA_W  = 3;
   localparam int CSR_W   = 3;
   localparam int INDEX_W = 2;

   // request actions
   localparam logic [1:0] ACT_LATCH  = 2'd0;
   localparam logic [1:0] ACT_STROBE = 2'd1;
   localparam logic [1:0] ACT_READ0  = 2'd2;
   localparam logic [1:0] ACT_READ1  = 2'd3;

   // configuration register indexes
   localparam logic [INDEX_W-1:0] CSR_ARCADE_MODE = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_SWAP_TYPE   = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_FOUR_PLAYER = 2'd2;

   // arcade remap variants
   localparam logic [2:0] SWAP_NONE         = 3'd0;
   localparam logic [2:0] SWAP_CROSS        = 3'd1;
   localparam logic [2:0] SWAP_SHARE        = 3'd2;
   localparam logic [2:0] SWAP_SHARE_CROSS  = 3'd3;
   localparam logic [2:0] SWAP_START        = 3'd4;
   localparam logic [2:0] SWAP_START_CROSS  = 3'd5;
   localparam logic [2:0] SWAP_SELECT_START = 3'd6;
   localparam logic [2:0] SWAP_OFF          = 3'd7;

   localparam logic [PAD_W-1:0]  PAD_KEEP  = 8'hF3;
   localparam logic [PAD_W-1:0]  START_BIT = 8'h08;
   localparam logic [PORT_W-1:0] SIG_ZERO  = 20'h80000;
   localparam logic [PORT_W-1:0] SIG_ONE   = 20'h40000;

   typedef struct packed {
      logic       arcade_mode;
      logic [2:0] swap_type;
      logic       four_player;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [PAD_W-1:0] pad_one;
      logic [PAD_W-1:0] pad_two;
      logic [PAD_W-1:0] pad_three;
      logic [PAD_W-1:0] pad_four;
      logic             mic_pressed;
      logic             strobe_level;
   } op_type;

endpackage

FILE: design/game_controller_port_shifter.sv
// ----------------------------------------------------------------------------
// game_controller_port_shifter
// Controller port strobe and shift block: latch, strobe load, serial reads.
// ----------------------------------------------------------------------------
//  channel | ports                       | moves
//  --------+-----------------------------+--------------------------------
//  req     | req_valid / req_stall       | one request: action and payload
//  rsp     | rsp_valid / rsp_stall       | 3-bit read data, reads only
//  csr     | csr_write_en / index / data | mode register write
//
//  One request per cycle while req_stall is low. A request is executed against
//  the port state in the cycle it fires from the input register, and a read's
//  data lands in the result register at the next edge. Reset clears all state,
//  the snapshot and the mode registers, but not the result data. A stalled
//  result holds reads and all behind them; a latch or strobe ahead goes on.
// ----------------------------------------------------------------------------
module game_controller_port_shifter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_action,
   input  logic [gcps_pkg::PAD_W-1:0]         req_pad_one,
   input  logic [gcps_pkg::PAD_W-1:0]         req_pad_two,
   input  logic [gcps_pkg::PAD_W-1:0]         req_pad_three,
   input  logic [gcps_pkg::PAD_W-1:0]         req_pad_four,
   input  logic                               req_mic_pressed,
   input  logic                               req_strobe_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gcps_pkg::DATA_W-1:0]        rsp_read_data,
   input  logic                               csr_write_en,
   input  logic [gcps_pkg::INDEX_W-1:0]       csr_index,
   input  logic [gcps_pkg::CSR_W-1:0]         csr_write_data
);

   gcps_pkg::cfg_type              cfg_ff, cfg_in;
   gcps_pkg::op_type               op_ff, op_in;
   logic                           op_valid_ff, op_valid_in;
   logic                           out_valid_ff, out_valid_in;
   logic [gcps_pkg::DATA_W-1:0]    out_data_ff, out_data_in;
   logic [gcps_pkg::DATA_W-1:0]    read_data;
   logic                           is_read, fire, take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         priority if (csr_index == gcps_pkg::CSR_ARCADE_MODE) begin
            cfg_in.arcade_mode = csr_write_data[0];
         end else if (csr_index == gcps_pkg::CSR_SWAP_TYPE) begin
            cfg_in.swap_type = csr_write_data;
         end else if (csr_index == gcps_pkg::CSR_FOUR_PLAYER) begin
            cfg_in.four_player = csr_write_data[0];
         end else begin
            cfg_in = cfg_ff;
         end
      end
   end

   always_comb begin
      is_read   = op_ff.action[1];
      // reads need room in the result register
      fire      = op_valid_ff && (!is_read || !out_valid_ff || !rsp_stall);
      req_stall = op_valid_ff && !fire;
      take      = req_valid && !req_stall;

      op_in       = take ? gcps_pkg::op_type'{action:       req_action,
                                              pad_one:      req_pad_one,
                                              pad_two:      req_pad_two,
                                              pad_three:    req_pad_three,
                                              pad_four:     req_pad_four,
                                              mic_pressed:  req_mic_pressed,
                                              strobe_level: req_strobe_level}
                         : op_ff;
      op_valid_in = take || (op_valid_ff && !fire);

      priority if (fire && is_read) begin
         out_valid_in = 1'b1;
         out_data_in  = read_data;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
         out_data_in  = out_data_ff;
      end
   end

   gcps_ports u_ports (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fire      (fire),
      .op        (op_ff),
      .read_data (read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         op_ff        <= '0;
         op_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         op_ff        <= op_in;
         op_valid_ff  <= op_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;

endmodule

FILE: design/gcps_remap.sv
// ----------------------------------------------------------------------------
// gcps_remap
// Builds the two port load values from the latched pads and the mode.
// ----------------------------------------------------------------------------
module gcps_remap (
   input  gcps_pkg::cfg_type                  cfg,
   input  logic [gcps_pkg::PAD_W-1:0]         pad_a,
   input  logic [gcps_pkg::PAD_W-1:0]         pad_b,
   input  logic [gcps_pkg::PAD_W-1:0]         pad_c,
   input  logic [gcps_pkg::PAD_W-1:0]         pad_d,
   output logic [gcps_pkg::PORT_W-1:0]        load_zero,
   output logic [gcps_pkg::PORT_W-1:0]        load_one
);

   logic [gcps_pkg::PAD_W-1:0] m0, m1, s0, s1, s1_hi, sel0, sel1;
   logic [gcps_pkg::PAD_W-1:0] arc0, arc1;

   always_comb begin
      m0    = pad_a & gcps_pkg::PAD_KEEP;
      m1    = pad_b & gcps_pkg::PAD_KEEP;
      // start moves down into the select position
      s0    = {5'd0, pad_a[3], 2'd0};
      s1    = {5'd0, pad_b[3], 2'd0};
      s1_hi = {4'd0, pad_b[3], 3'd0};
      sel0  = {4'd0, pad_a[2], 3'd0};
      sel1  = {4'd0, pad_b[2], 3'd0};
      unique case (cfg.swap_type)
         gcps_pkg::SWAP_NONE: begin
            arc0 = m0 | s0;
            arc1 = m1 | s1;
         end
         gcps_pkg::SWAP_CROSS: begin
            arc0 = m1 | s0;
            arc1 = m0 | s1;
         end
         gcps_pkg::SWAP_SHARE: begin
            arc0 = m0 | s0 | s1_hi;
            arc1 = m1;
         end
         gcps_pkg::SWAP_SHARE_CROSS: begin
            arc0 = m1 | s0 | s1_hi;
            arc1 = m0;
         end
         gcps_pkg::SWAP_START: begin
            arc0 = m0 | s0 | gcps_pkg::START_BIT;
            arc1 = m1 | s1 | gcps_pkg::START_BIT;
         end
         gcps_pkg::SWAP_START_CROSS: begin
            arc0 = m1 | s0 | gcps_pkg::START_BIT;
            arc1 = m0 | s1 | gcps_pkg::START_BIT;
         end
         gcps_pkg::SWAP_SELECT_START: begin
            arc0 = m0 | s0 | sel0;
            arc1 = m1 | s1 | sel1;
         end
         gcps_pkg::SWAP_OFF: begin
            arc0 = '0;
            arc1 = '0;
         end
         default: begin
            arc0 = '0;
            arc1 = '0;
         end
      endcase

      priority if (cfg.arcade_mode) begin
         load_zero = {12'd0, arc0};
         load_one  = {12'd0, arc1};
      end else if (cfg.four_player) begin
         load_zero = {4'd0, pad_c, pad_a} | gcps_pkg::SIG_ZERO;
         load_one  = {4'd0, pad_d, pad_b} | gcps_pkg::SIG_ONE;
      end else begin
         load_zero = {12'd0, pad_a};
         load_one  = {12'd0, pad_b};
      end
   end

endmodule

FILE: design/gcps_ports.sv
// ----------------------------------------------------------------------------
// gcps_ports
// Latched snapshot, strobe tracking and the port shift registers.
// ----------------------------------------------------------------------------
module gcps_ports (
   input  logic                               clock,
   input  logic                               reset,
   input  gcps_pkg::cfg_type                  cfg,
   input  logic                               fire,
   input  gcps_pkg::op_type                   op,
   output logic [gcps_pkg::DATA_W-1:0]        read_data
);

   logic                          strobe_held_ff, strobe_held_in;
   logic [gcps_pkg::PORT_W-1:0]   port_zero_ff, port_zero_in;
   logic [gcps_pkg::PORT_W-1:0]   port_one_ff, port_one_in;
   logic [gcps_pkg::PAD_W-1:0]    extra_zero_ff, extra_zero_in;
   logic [gcps_pkg::PAD_W-1:0]    extra_one_ff, extra_one_in;
   logic [gcps_pkg::PAD_W-1:0]    pad_a_ff, pad_a_in, pad_b_ff, pad_b_in;
   logic [gcps_pkg::PAD_W-1:0]    pad_c_ff, pad_c_in, pad_d_ff, pad_d_in;
   logic                          mic_ff, mic_in;
   logic [gcps_pkg::PORT_W-1:0]   load_zero, load_one;

   gcps_remap u_remap (
      .cfg       (cfg),
      .pad_a     (pad_a_ff),
      .pad_b     (pad_b_ff),
      .pad_c     (pad_c_ff),
      .pad_d     (pad_d_ff),
      .load_zero (load_zero),
      .load_one  (load_one)
   );

   always_comb begin
      strobe_held_in = strobe_held_ff;
      port_zero_in   = port_zero_ff;
      port_one_in    = port_one_ff;
      extra_zero_in  = extra_zero_ff;
      extra_one_in   = extra_one_ff;
      pad_a_in       = pad_a_ff;
      pad_b_in       = pad_b_ff;
      pad_c_in       = pad_c_ff;
      pad_d_in       = pad_d_ff;
      mic_in         = mic_ff;
      read_data      = '0;
      unique case (op.action)
         gcps_pkg::ACT_LATCH: begin
            pad_a_in = op.pad_one;
            pad_b_in = op.pad_two;
            pad_c_in = op.pad_three;
            pad_d_in = op.pad_four;
            mic_in   = op.mic_pressed;
         end
         gcps_pkg::ACT_STROBE: begin
            // load only on a falling strobe after a high write
            priority if (op.strobe_level) begin
               strobe_held_in = 1'b1;
            end else if (strobe_held_ff) begin
               strobe_held_in = 1'b0;
               port_zero_in   = load_zero;
               port_one_in    = load_one;
               extra_zero_in  = pad_c_ff;
               extra_one_in   = pad_d_ff;
            end else begin
               // low write with no high before it: load nothing
               strobe_held_in = 1'b0;
            end
         end
         gcps_pkg::ACT_READ0: begin
            read_data     = {mic_ff & ~cfg.arcade_mode, extra_zero_ff[0], port_zero_ff[0]};
            port_zero_in  = port_zero_ff >> 1;
            extra_zero_in = extra_zero_ff >> 1;
         end
         gcps_pkg::ACT_READ1: begin
            read_data    = {1'b0, extra_one_ff[0], port_one_ff[0]};
            port_one_in  = port_one_ff >> 1;
            extra_one_in = extra_one_ff >> 1;
         end
         default: begin
            read_data = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_held_ff <= 1'b0;
         port_zero_ff   <= '0;
         port_one_ff    <= '0;
         extra_zero_ff  <= '0;
         extra_one_ff   <= '0;
         pad_a_ff       <= '0;
         pad_b_ff       <= '0;
         pad_c_ff       <= '0;
         pad_d_ff       <= '0;
         mic_ff         <= 1'b0;
      end else if (fire) begin
         strobe_held_ff <= strobe_held_in;
         port_zero_ff   <= port_zero_in;
         port_one_ff    <= port_one_in;
         extra_zero_ff  <= extra_zero_in;
         extra_one_ff   <= extra_one_in;
         pad_a_ff       <= pad_a_in;
         pad_b_ff       <= pad_b_in;
         pad_c_ff       <= pad_c_in;
         pad_d_ff       <= pad_d_in;
         mic_ff         <= mic_in;
      end
   end

endmodule

FILE: bench/game_controller_port_shifter_checker.sv
// ----------------------------------------------------------------------------
// game_controller_port_shifter_checker
// Watches the request, result and mode-register ports of the controller port
// shifter. Keeps its own copy of the snapshot, strobe and shift registers,
// predicts the data of every accepted read and compares it with the results
// in order. Counts mismatches and reports how many reads are still owed.
// ----------------------------------------------------------------------------
module game_controller_port_shifter_checker
   import gcps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [PAD_W-1:0]   req_pad_one,
   input  logic [PAD_W-1:0]   req_pad_two,
   input  logic [PAD_W-1:0]   req_pad_three,
   input  logic [PAD_W-1:0]   req_pad_four,
   input  logic               req_mic_pressed,
   input  logic               req_strobe_level,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [DATA_W-1:0]  rsp_read_data,
   input  logic               csr_write_en,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]   csr_write_data,
   output int                 mismatch_count,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [PAD_W-1:0] SELECT_BIT  = 8'h04;
   localparam int               PRINT_LIMIT = 100;

   cfg_type           mode;
   logic              strobe_held;
   logic [PORT_W-1:0] main_sr [2];
   logic [PAD_W-1:0]  extra_sr [2];
   logic [PAD_W-1:0]  snap_pad [4];
   logic              snap_mic;
   logic [DATA_W-1:0] read_data_q [$];

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] MISMATCH: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic apply_request(input op_type r);
      logic [PAD_W-1:0]  a, b, m0, m1, st0, st1;
      logic [PAD_W-1:0]  arc0, arc1;
      logic [PORT_W-1:0] p0, p1;
      int                port;
      logic [DATA_W-1:0] data;
      a    = snap_pad[0];
      b    = snap_pad[1];
      m0   = a & PAD_KEEP;
      m1   = b & PAD_KEEP;
      // move start down into the select position
      st0  = (a & START_BIT) >> 1;
      st1  = (b & START_BIT) >> 1;
      arc0 = '0;
      arc1 = '0;
      p0   = '0;
      p1   = '0;
      case (r.action)
         ACT_LATCH: begin
            snap_pad[0] = r.pad_one;
            snap_pad[1] = r.pad_two;
            snap_pad[2] = r.pad_three;
            snap_pad[3] = r.pad_four;
            snap_mic    = r.mic_pressed;
         end
         ACT_STROBE: begin
            if (r.strobe_level) begin
               strobe_held = 1'b1;
            end else if (strobe_held) begin
               strobe_held = 1'b0;
               if (mode.arcade_mode) begin
                  case (mode.swap_type)
                     SWAP_NONE: begin
                        arc0 = m0 | st0;
                        arc1 = m1 | st1;
                     end
                     SWAP_CROSS: begin
                        arc0 = m1 | st0;
                        arc1 = m0 | st1;
                     end
                     SWAP_SHARE: begin
                        arc0 = m0 | st0 | (b & START_BIT);
                        arc1 = m1;
                     end
                     SWAP_SHARE_CROSS: begin
                        arc0 = m1 | st0 | (b & START_BIT);
                        arc1 = m0;
                     end
                     SWAP_START: begin
                        arc0 = m0 | st0 | START_BIT;
                        arc1 = m1 | st1 | START_BIT;
                     end
                     SWAP_START_CROSS: begin
                        arc0 = m1 | st0 | START_BIT;
                        arc1 = m0 | st1 | START_BIT;
                     end
                     SWAP_SELECT_START: begin
                        arc0 = m0 | st0 | ((a & SELECT_BIT) << 1);
                        arc1 = m1 | st1 | ((b & SELECT_BIT) << 1);
                     end
                     default: begin
                        arc0 = '0;
                        arc1 = '0;
                     end
                  endcase
                  p0 = {12'b0, arc0};
                  p1 = {12'b0, arc1};
               end else if (mode.four_player) begin
                  p0 = {4'b0, snap_pad[2], a} | SIG_ZERO;
                  p1 = {4'b0, snap_pad[3], b} | SIG_ONE;
               end else begin
                  p0 = {12'b0, a};
                  p1 = {12'b0, b};
               end
               main_sr[0]  = p0;
               main_sr[1]  = p1;
               extra_sr[0] = snap_pad[2];
               extra_sr[1] = snap_pad[3];
            end
         end
         ACT_READ0, ACT_READ1: begin
            port = (r.action == ACT_READ1) ? 1 : 0;
            data = {1'b0, extra_sr[port][0], main_sr[port][0]};
            main_sr[port]  = main_sr[port] >> 1;
            extra_sr[port] = extra_sr[port] >> 1;
            if (port == 0 && !mode.arcade_mode) begin
               data[2] = snap_mic;
            end
            read_data_q.push_back(data);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (reset) begin
         mode           = '0;
         strobe_held    = 1'b0;
         main_sr[0]     = '0;
         main_sr[1]     = '0;
         extra_sr[0]    = '0;
         extra_sr[1]    = '0;
         for (int i = 0; i < 4; i++) snap_pad[i] = '0;
         snap_mic       = 1'b0;
         read_data_q.delete();
         mismatch_count = 0;
      end else begin
         // retire results first: a read taken at this edge is not yet in the result register
         if (rsp_valid && !rsp_stall) begin
            if (read_data_q.size() == 0) begin
               report_mismatch($sformatf("read data %0d with no read pending",
                                         rsp_read_data));
            end else begin
               want = read_data_q.pop_front();
               if (rsp_read_data !== want) begin
                  report_mismatch($sformatf("read data %0d, expected %0d",
                                            rsp_read_data, want));
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_ARCADE_MODE: mode.arcade_mode = csr_write_data[0];
               CSR_SWAP_TYPE:   mode.swap_type   = csr_write_data[2:0];
               CSR_FOUR_PLAYER: mode.four_player = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            apply_request({req_action, req_pad_one, req_pad_two, req_pad_three,
                           req_pad_four, req_mic_pressed, req_strobe_level});
         end
      end
      outstanding <= read_data_q.size();
   end

endmodule

FILE: bench/game_controller_port_shifter_tb.sv
// ----------------------------------------------------------------------------
// game_controller_port_shifter_tb
// Drives the controller port shifter with a directed opening and then random
// latch / strobe / read scans under every mode setting, with random idling
// on both channels, a long result hold-off and drained pauses. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module game_controller_port_shifter_tb;
   import gcps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 1850;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = RANDOM_ITEMS / PHASES;
   localparam int IDLE_PCT      = 29;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_action;
   logic [PAD_W-1:0]   req_pad_one;
   logic [PAD_W-1:0]   req_pad_two;
   logic [PAD_W-1:0]   req_pad_three;
   logic [PAD_W-1:0]   req_pad_four;
   logic               req_mic_pressed;
   logic               req_strobe_level;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [DATA_W-1:0]  rsp_read_data;
   logic               csr_write_en;
   logic [INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]   csr_write_data;

   int   mismatch_count;
   int   outstanding;
   logic no_idle;
   int   hold_asks;
   int   holds_served;
   int   quiet_cycles;
   int   sent;

   always #1 clock = ~clock;

   game_controller_port_shifter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_pad_one      (req_pad_one),
      .req_pad_two      (req_pad_two),
      .req_pad_three    (req_pad_three),
      .req_pad_four     (req_pad_four),
      .req_mic_pressed  (req_mic_pressed),
      .req_strobe_level (req_strobe_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   game_controller_port_shifter_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_pad_one      (req_pad_one),
      .req_pad_two      (req_pad_two),
      .req_pad_three    (req_pad_three),
      .req_pad_four     (req_pad_four),
      .req_mic_pressed  (req_mic_pressed),
      .req_strobe_level (req_strobe_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on demand
   initial begin
      rsp_stall <= 1'b0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_asks) begin
            holds_served = hold_asks;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic logic [PAD_W-1:0] random_pad();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return PAD_W'($urandom_range(255));
      endcase
   endfunction

   function automatic op_type random_op();
      op_type r;
      r.action       = 2'($urandom_range(3));
      r.pad_one      = random_pad();
      r.pad_two      = random_pad();
      r.pad_three    = random_pad();
      r.pad_four     = random_pad();
      r.mic_pressed  = 1'($urandom_range(1));
      r.strobe_level = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic send_request(input op_type r);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_pad_one      <= r.pad_one;
      req_pad_two      <= r.pad_two;
      req_pad_three    <= r.pad_three;
      req_pad_four     <= r.pad_four;
      req_mic_pressed  <= r.mic_pressed;
      req_strobe_level <= r.strobe_level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic send_latch(input logic [PAD_W-1:0] p1, p2, p3, p4, input logic mic);
      op_type r;
      r             = random_op();
      r.action      = ACT_LATCH;
      r.pad_one     = p1;
      r.pad_two     = p2;
      r.pad_three   = p3;
      r.pad_four    = p4;
      r.mic_pressed = mic;
      send_request(r);
   endtask

   task automatic send_strobe(input logic level);
      op_type r;
      r              = random_op();
      r.action       = ACT_STROBE;
      r.strobe_level = level;
      send_request(r);
   endtask

   task automatic send_read(input logic [1:0] port_action);
      op_type r;
      r        = random_op();
      r.action = port_action;
      send_request(r);
   endtask

   // latch, strobe high (mostly) then low, sometimes high again, then a run of reads that may exhaust a port
   task automatic send_scan();
      int reads;
      send_latch(random_pad(), random_pad(), random_pad(), random_pad(),
                 1'($urandom_range(1)));
      if ($urandom_range(9) != 0) send_strobe(1'b1);
      send_strobe(1'b0);
      if ($urandom_range(4) == 0) send_strobe(1'b1);
      reads = $urandom_range(24);
      repeat (reads) send_read($urandom_range(1) ? ACT_READ1 : ACT_READ0);
   endtask

   // drop valid, let every read come back and the last latch or strobe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic arcade, input logic [2:0] swap, input logic four);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_ARCADE_MODE;
      csr_write_data <= {2'b0, arcade};
      @(posedge clock);
      csr_index      <= CSR_SWAP_TYPE;
      csr_write_data <= swap;
      @(posedge clock);
      csr_index      <= CSR_FOUR_PLAYER;
      csr_write_data <= {2'b0, four};
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      logic       paused;
      logic       arcade;
      logic [2:0] swap;
      logic       four;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= ACT_LATCH;
      req_pad_one      <= '0;
      req_pad_two      <= '0;
      req_pad_three    <= '0;
      req_pad_four     <= '0;
      req_mic_pressed  <= 1'b0;
      req_strobe_level <= 1'b0;
      csr_write_en     <= 1'b0;
      csr_index        <= CSR_ARCADE_MODE;
      csr_write_data   <= '0;
      no_idle          <= 1'b0;
      hold_asks        <= 0;
      paused = 1'b0;
      sent   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // straight out of reset the ports read zero
      send_read(ACT_READ0);
      // a falling strobe with no high before it loads nothing
      send_latch(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_strobe(1'b0);
      send_read(ACT_READ0);
      send_read(ACT_READ1);
      // strobe held high: nothing loads until it falls
      send_strobe(1'b1);
      send_read(ACT_READ0);
      send_strobe(1'b0);
      send_read(ACT_READ0);
      send_read(ACT_READ1);
      // a new latch alone does not reload; a second fall does not either
      send_latch(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_read(ACT_READ0);
      send_strobe(1'b0);
      send_read(ACT_READ1);

      wait_idle();
      write_mode(1'b0, SWAP_NONE, 1'b1);
      send_latch(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1);
      send_strobe(1'b1);
      send_strobe(1'b0);
      send_read(ACT_READ1);
      send_read(ACT_READ0);

      // four-player is overridden by the arcade remap
      wait_idle();
      write_mode(1'b1, SWAP_SELECT_START, 1'b1);
      send_latch(8'h0C, 8'h08, 8'hFF, 8'hFF, 1'b1);
      send_strobe(1'b1);
      send_strobe(1'b0);
      send_read(ACT_READ0);
      send_read(ACT_READ1);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         if (ph < 8) begin
            arcade = 1'b1;
            swap   = 3'(ph);
            four   = 1'($urandom_range(1));
         end else if (ph == 8) begin
            arcade = 1'b0;
            swap   = SWAP_NONE;
            four   = 1'b0;
         end else if (ph == 9) begin
            arcade = 1'b0;
            swap   = 3'($urandom_range(7));
            four   = 1'b1;
         end else begin
            arcade = 1'($urandom_range(1));
            swap   = 3'($urandom_range(7));
            four   = 1'($urandom_range(1));
         end
         write_mode(arcade, swap, four);
         no_idle <= (ph == 3);
         // hold results off while requests keep coming, to fill the block
         if (ph == 5) hold_asks <= hold_asks + 1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (ph == 7 && !paused && sent > PHASE_ITEMS / 2) begin
               wait_idle();
               paused = 1'b1;
            end
            if ($urandom_range(4) == 0) begin
               send_request(random_op());
            end else begin
               send_scan();
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
